### rtl/c2s_pkg.sv
// c2s_pkg: constants, table builders and helpers for the cartesian to spherical block
// no dependencies; used by c2s_ifs, c2s_cordic_cell, cartesian_to_spherical and c2s_checker
`default_nettype none

package c2s_pkg;

	localparam int COORD_BITS_DEF      = 24;
	localparam int ANGLE_FRAC_BITS_DEF = 16;

	localparam int RADIUS_W    = 24;
	localparam int AZIMUTH_W   = 25;
	localparam int ELEVATION_W = 24;

	localparam int CORDIC_STEPS = 60;
	localparam int ANG_Q        = 60;
	localparam int DEG_Q        = 56;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam logic CFG_IDX_DEGREES = 1'b0;

	// restoring long division, elaboration only
	function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
		logic [127:0] r;
		logic [127:0] q;
		r = '0;
		q = '0;
		for (int i = 127; i >= 0; i--) begin
			r = {r[126:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/n) in Q60 by its series
	function automatic logic [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		p   = 64'(udiv(128'(64'd1 << 60), 128'(n)));
		sum = '0;
		k   = '0;
		while (p != 64'd0) begin
			t   = 64'(udiv(128'(p), 128'(2 * k + 64'd1)));
			sum = k[0] ? sum - t : sum + t;
			k   = k + 64'd1;
			p   = 64'(udiv(128'(p), 128'(n * n)));
		end
		return sum;
	endfunction

	// atan(2^-i) in Q60, i >= 1
	function automatic logic [63:0] atan_pow2(input int i);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		p   = (64'd1 << 60) >> i;
		sum = '0;
		k   = '0;
		while (p != 64'd0) begin
			t   = 64'(udiv(128'(p), 128'(2 * k + 64'd1)));
			sum = k[0] ? sum - t : sum + t;
			k   = k + 64'd1;
			p   = (2 * i >= 64) ? 64'd0 : (p >> (2 * i));
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_entry(input int i);
		if (i == 0) begin
			return 64'(4 * atan_recip(64'd5)) - atan_recip(64'd239);
		end
		return atan_pow2(i);
	endfunction

	localparam logic [63:0] PI_Q60     = 64'(4 * atan_entry(0));
	localparam logic [63:0] TWO_PI_Q60 = 64'(2 * PI_Q60);
	// 180/pi in Q56
	localparam logic [63:0] DEG_SCALE  = 64'(udiv(128'(180) << 116, 128'(PI_Q60)));

	// round(a * b / 2^s), elaboration only
	function automatic logic [63:0] mul_shr_round_c(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		logic [63:0]  v;
		p = 128'(a) * 128'(b);
		v = 64'(p >> (s - 1));
		return (v >> 1) + {63'd0, v[0]};
	endfunction

	// number of significant bits
	function automatic logic [6:0] bitlen(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/c2s_ifs.sv
// c2s_point_if and c2s_sphere_if: valid/ready channels of the block
// depends on c2s_pkg
`default_nettype none

interface c2s_point_if #(
	parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_coord;
	logic signed [COORD_BITS-1:0] y_coord;
	logic signed [COORD_BITS-1:0] z_coord;

	modport source(output valid, output x_coord, output y_coord, output z_coord, input ready);
	modport sink(input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

interface c2s_sphere_if;
	logic                             valid;
	logic                             ready;
	logic [c2s_pkg::RADIUS_W-1:0]     radius;
	logic [c2s_pkg::AZIMUTH_W-1:0]    azimuth;
	logic [c2s_pkg::ELEVATION_W-1:0]  elevation;

	modport source(output valid, output radius, output azimuth, output elevation, input ready);
	modport sink(input valid, input radius, input azimuth, input elevation, output ready);
endinterface

`default_nettype wire

### rtl/c2s_sqrt_cell.sv
// c2s_sqrt_cell: one result bit of a digit-by-digit integer square root
// depends on nothing beyond its parameters
`default_nettype none

module c2s_sqrt_cell #(
	parameter int W    = 50,
	parameter int STEP = 0,
	parameter int SB_W = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            valid,
	input  wire logic [W-1:0]    n,
	input  wire logic [W-1:0]    res,
	input  wire logic [SB_W-1:0] sb,
	output logic                 valid_q,
	output logic [W-1:0]         n_q,
	output logic [W-1:0]         res_q,
	output logic [SB_W-1:0]      sb_q
);

	localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

	logic [W-1:0] trial;

	assign trial = res + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q <= sb;
			if (n >= trial) begin
				n_q   <= n - trial;
				res_q <= (res >> 1) + BIT;
			end else begin
				n_q   <= n;
				res_q <= res >> 1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/c2s_cordic_cell.sv
// c2s_cordic_cell: one vectoring rotation of the atan2 chain
// depends on c2s_pkg for the arctangent table
`default_nettype none

module c2s_cordic_cell #(
	parameter int STEP = 0,
	parameter int SB_W = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            valid,
	input  wire logic [63:0]     x,
	input  wire logic [63:0]     y,
	input  wire logic [63:0]     a,
	input  wire logic [SB_W-1:0] sb,
	output logic                 valid_q,
	output logic [63:0]          x_q,
	output logic [63:0]          y_q,
	output logic [63:0]          a_q,
	output logic [SB_W-1:0]      sb_q
);

	localparam logic [63:0] ANG = c2s_pkg::atan_entry(STEP);

	logic [63:0] ys;
	logic [63:0] xs;

	assign ys = 64'($signed(y) >>> STEP);
	assign xs = x >> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	// y is read as signed, x stays non-negative
	always_ff @(posedge clk) begin
		if (en) begin
			sb_q <= sb;
			if (!y[63]) begin
				x_q <= x + ys;
				y_q <= y - xs;
				a_q <= a + ANG;
			end else begin
				x_q <= x - ys;
				y_q <= y + xs;
				a_q <= a - ANG;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cartesian_to_spherical.sv
// cartesian_to_spherical: top level, magnitude, square root and two atan2 chains
// depends on c2s_pkg, c2s_ifs, c2s_sqrt_cell, c2s_cordic_cell
//
// channel   dir   payload                         handshake
// point     in    x_coord, y_coord, z_coord       valid / ready
// result    out   radius, azimuth, elevation      valid / ready
// apb       cfg   angle_in_degrees at address 0   psel / penable, pready tied high
//
// one item per cycle while the skid stage is empty; each item passes from accept to result
// through the numbered stages, the square root cells and the two 60-cell chains
// the whole chain advances together; a result held on the output fills a one-item
// skid stage, and only then is ready dropped
// reset clears the valid bits and the mode register, no payload is reset
`default_nettype none

module cartesian_to_spherical #(
	parameter int COORD_BITS      = c2s_pkg::COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = c2s_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	c2s_point_if.sink                           point,
	c2s_sphere_if.source                        result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [c2s_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int N        = COORD_BITS;
	localparam int SQ_FULL  = 2 * N + 2;
	localparam int SQ_W     = (SQ_FULL > 64) ? 64 : SQ_FULL;
	localparam int SQ_CELLS = SQ_W / 2;
	localparam int STEPS    = c2s_pkg::CORDIC_STEPS;
	localparam int RW       = c2s_pkg::RADIUS_W;
	localparam int SH_RAD   = c2s_pkg::ANG_Q - ANGLE_FRAC_BITS - 1;
	localparam int DEG_SH   = c2s_pkg::ANG_Q + c2s_pkg::DEG_Q - ANGLE_FRAC_BITS;

	localparam logic [63:0] FULL_RAD_V = c2s_pkg::TWO_PI_Q60 >> SH_RAD;
	localparam logic [63:0] FULL_RAD   = (FULL_RAD_V >> 1) + {63'd0, FULL_RAD_V[0]};
	localparam logic [63:0] FULL_DEG   =
		c2s_pkg::mul_shr_round_c(c2s_pkg::TWO_PI_Q60, c2s_pkg::DEG_SCALE, DEG_SH);

	typedef struct packed {
		logic [63:0]   sx;
		logic [63:0]   sy;
		logic [N-1:0]  mz;
		logic [6:0]    sh;
		logic          xn;
		logic          yn;
		logic          zn;
		logic          zall;
		logic          zxy;
	} sq_sb_t;

	typedef struct packed {
		logic [RW-1:0] rad;
		logic [N-1:0]  mz;
		logic [6:0]    sh;
		logic          xn;
		logic          yn;
		logic          zn;
		logic          zall;
		logic          zxy;
	} c1_sb_t;

	typedef struct packed {
		logic [RW-1:0] rad;
		logic [63:0]   az;
		logic          zn;
		logic          zall;
		logic          zxy;
	} c2_sb_t;

	function automatic logic [63:0] shift_by(input logic [63:0] v, input logic signed [8:0] k);
		logic signed [8:0] nk;
		nk = -k;
		if (k >= 0) begin
			return (k >= 9'sd64) ? 64'd0 : (v << k[5:0]);
		end
		return (nk >= 9'sd64) ? 64'd0 : (v >> nk[5:0]);
	endfunction

	function automatic logic [63:0] clamp_neg(input logic [63:0] a);
		return a[63] ? 64'd0 : a;
	endfunction

	// configuration
	logic deg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == c2s_pkg::CFG_IDX_DEGREES) begin
			deg_q <= pwdata[0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			c2s_pkg::CFG_IDX_DEGREES: prdata = {31'd0, deg_q};
			default:                  prdata = '0;
		endcase
	end

	// flow control
	logic skid_valid_q;
	logic en;

	assign en          = !skid_valid_q;
	assign point.ready = en;

	// stage 1: magnitudes and signs
	logic [N-1:0] xr;
	logic [N-1:0] yr;
	logic [N-1:0] zr;
	logic         v_s1;
	logic [N-1:0] mx_s1;
	logic [N-1:0] my_s1;
	logic [N-1:0] mz_s1;
	logic         xn_s1;
	logic         yn_s1;
	logic         zn_s1;

	assign xr = point.x_coord;
	assign yr = point.y_coord;
	assign zr = point.z_coord;

	// stage 2: squares and the normalising shift of the plane vector
	logic [N-1:0]   big;
	logic [2*N-1:0] sqx_c;
	logic [2*N-1:0] sqy_c;
	logic [2*N-1:0] sqz_c;
	logic           v_s2;
	logic [2*N-1:0] sqx_s2;
	logic [2*N-1:0] sqy_s2;
	logic [2*N-1:0] sqz_s2;
	logic [N-1:0]   mx_s2;
	logic [N-1:0]   my_s2;
	logic [N-1:0]   mz_s2;
	logic [6:0]     sh_s2;
	logic           xn_s2;
	logic           yn_s2;
	logic           zn_s2;
	logic           zall_s2;
	logic           zxy_s2;

	assign big   = (mx_s1 > my_s1) ? mx_s1 : my_s1;
	assign sqx_c = mx_s1 * mx_s1;
	assign sqy_c = my_s1 * my_s1;
	assign sqz_c = mz_s1 * mz_s1;

	// stage 3: sum of squares, shifted plane vector
	logic [SQ_FULL-1:0] sum_c;
	logic               v_s3;
	logic [SQ_W-1:0]    sum_s3;
	sq_sb_t             sb_s3;

	assign sum_c = SQ_FULL'(sqx_s2) + SQ_FULL'(sqy_s2) + SQ_FULL'(sqz_s2);

	// square root cells
	logic            sq_v   [0:SQ_CELLS];
	logic [SQ_W-1:0] sq_n   [0:SQ_CELLS];
	logic [SQ_W-1:0] sq_r   [0:SQ_CELLS];
	sq_sb_t          sq_sb  [0:SQ_CELLS];

	assign sq_v[0]  = v_s3;
	assign sq_n[0]  = sum_s3;
	assign sq_r[0]  = '0;
	assign sq_sb[0] = sb_s3;

	for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
		c2s_sqrt_cell #(
			.W    (SQ_W),
			.STEP (j),
			.SB_W ($bits(sq_sb_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (sq_v[j]),
			.n       (sq_n[j]),
			.res     (sq_r[j]),
			.sb      (sq_sb[j]),
			.valid_q (sq_v[j+1]),
			.n_q     (sq_n[j+1]),
			.res_q   (sq_r[j+1]),
			.sb_q    (sq_sb[j+1])
		);
	end

	// stage 4: rounded radius, start of the azimuth chain
	sq_sb_t      sq_out;
	logic [SQ_W-1:0] rad_c;
	logic        v_s4;
	logic [63:0] c1x_s4;
	logic [63:0] c1y_s4;
	c1_sb_t      c1sb_s4;

	assign sq_out = sq_sb[SQ_CELLS];
	assign rad_c  = (sq_n[SQ_CELLS] > sq_r[SQ_CELLS]) ? sq_r[SQ_CELLS] + SQ_W'(1) :
		sq_r[SQ_CELLS];

	logic        c1v  [0:STEPS];
	logic [63:0] c1x  [0:STEPS];
	logic [63:0] c1y  [0:STEPS];
	logic [63:0] c1a  [0:STEPS];
	c1_sb_t      c1sb [0:STEPS];

	assign c1v[0]  = v_s4;
	assign c1x[0]  = c1x_s4;
	assign c1y[0]  = c1y_s4;
	assign c1a[0]  = '0;
	assign c1sb[0] = c1sb_s4;

	for (genvar j = 0; j < STEPS; j++) begin : g_az
		c2s_cordic_cell #(
			.STEP (j),
			.SB_W ($bits(c1_sb_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (c1v[j]),
			.x       (c1x[j]),
			.y       (c1y[j]),
			.a       (c1a[j]),
			.sb      (c1sb[j]),
			.valid_q (c1v[j+1]),
			.x_q     (c1x[j+1]),
			.y_q     (c1y[j+1]),
			.a_q     (c1a[j+1]),
			.sb_q    (c1sb[j+1])
		);
	end

	// stage 5: quadrant fold, plane radius gain correction products
	c1_sb_t      c1_out;
	logic [63:0] a1;
	logic [63:0] az_c;
	logic        v_s5;
	logic [63:0] az_s5;
	logic [63:0] pl_s5;
	logic [63:0] ph_s5;
	c1_sb_t      sb_s5;

	assign c1_out = c1sb[STEPS];
	assign a1     = clamp_neg(c1a[STEPS]);

	always_comb begin
		case ({c1_out.xn, c1_out.yn})
			2'b00:   az_c = a1;
			2'b10:   az_c = c2s_pkg::PI_Q60 - a1;
			2'b11:   az_c = c2s_pkg::PI_Q60 + a1;
			default: az_c = c2s_pkg::TWO_PI_Q60 - a1;
		endcase
	end

	// stage 6: plane radius rounded
	logic [95:0] rho_p;
	logic [64:0] rho_v;
	logic        v_s6;
	logic [63:0] rho_s6;
	logic [63:0] az_s6;
	c1_sb_t      sb_s6;

	assign rho_p = (96'(ph_s5) << 32) + 96'(pl_s5);
	assign rho_v = 65'(rho_p >> 31);

	// stage 7: common normalisation of z and the plane radius
	logic [7:0]        br_c;
	logic [7:0]        tz_c;
	logic [7:0]        top_c;
	logic signed [8:0] t_c;
	logic              v_s7;
	logic [63:0]       rho_s7;
	logic [63:0]       az_s7;
	logic signed [8:0] k1_s7;
	logic signed [8:0] k2_s7;
	c1_sb_t            sb_s7;

	assign br_c  = {1'b0, c2s_pkg::bitlen(rho_s6)};
	assign tz_c  = {1'b0, c2s_pkg::bitlen(64'(sb_s6.mz))} + {1'b0, sb_s6.sh};
	assign top_c = (br_c > tz_c) ? br_c : tz_c;
	assign t_c   = 9'sd59 - $signed({1'b0, top_c});

	// stage 8: shifted operands of the elevation chain
	logic        v_s8;
	logic [63:0] c2x_s8;
	logic [63:0] c2y_s8;
	c2_sb_t      c2sb_s8;

	logic        c2v  [0:STEPS];
	logic [63:0] c2x  [0:STEPS];
	logic [63:0] c2y  [0:STEPS];
	logic [63:0] c2a  [0:STEPS];
	c2_sb_t      c2sb [0:STEPS];

	assign c2v[0]  = v_s8;
	assign c2x[0]  = c2x_s8;
	assign c2y[0]  = c2y_s8;
	assign c2a[0]  = '0;
	assign c2sb[0] = c2sb_s8;

	for (genvar j = 0; j < STEPS; j++) begin : g_el
		c2s_cordic_cell #(
			.STEP (j),
			.SB_W ($bits(c2_sb_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (c2v[j]),
			.x       (c2x[j]),
			.y       (c2y[j]),
			.a       (c2a[j]),
			.sb      (c2sb[j]),
			.valid_q (c2v[j+1]),
			.x_q     (c2x[j+1]),
			.y_q     (c2y[j+1]),
			.a_q     (c2a[j+1]),
			.sb_q    (c2sb[j+1])
		);
	end

	// stage 9: elevation fold and the axis cases
	c2_sb_t      c2_out;
	logic [63:0] e_c;
	logic [63:0] az9_c;
	logic [63:0] el9_c;
	logic        v_s9;
	logic [63:0] az_s9;
	logic [63:0] el_s9;
	logic [RW-1:0] rad_s9;

	assign c2_out = c2sb[STEPS];
	assign e_c    = clamp_neg(c2a[STEPS]);

	always_comb begin
		az9_c = c2_out.az;
		el9_c = c2_out.zn ? c2s_pkg::PI_Q60 - e_c : e_c;
		if (c2_out.zall) begin
			az9_c = '0;
			el9_c = '0;
		end else if (c2_out.zxy) begin
			// on the z axis
			az9_c = '0;
			el9_c = c2_out.zn ? c2s_pkg::PI_Q60 : 64'd0;
		end
	end

	// stage 10: degree partial products, radian rounding
	logic [63:0] azrv_c;
	logic [63:0] elrv_c;
	logic        v_s10;
	logic [63:0] azp_s10 [4];
	logic [63:0] elp_s10 [4];
	logic [63:0] azr_s10;
	logic [63:0] elr_s10;
	logic [RW-1:0] rad_s10;

	assign azrv_c = az_s9 >> SH_RAD;
	assign elrv_c = el_s9 >> SH_RAD;

	// stage 11: cross terms
	logic        v_s11;
	logic [63:0] azlo_s11;
	logic [63:0] azhi_s11;
	logic [64:0] azmid_s11;
	logic [63:0] ello_s11;
	logic [63:0] elhi_s11;
	logic [64:0] elmid_s11;
	logic [63:0] azr_s11;
	logic [63:0] elr_s11;
	logic [RW-1:0] rad_s11;

	// stage 12: degree products rounded, mode selected
	logic [127:0] azprod_c;
	logic [127:0] elprod_c;
	logic [63:0]  azdv_c;
	logic [63:0]  eldv_c;
	logic         v_s12;
	logic [63:0]  az_s12;
	logic [63:0]  el_s12;
	logic [RW-1:0] rad_s12;

	assign azprod_c = (128'(azhi_s11) << 64) + (128'(azmid_s11) << 32) + 128'(azlo_s11);
	assign elprod_c = (128'(elhi_s11) << 64) + (128'(elmid_s11) << 32) + 128'(ello_s11);
	assign azdv_c   = 64'(azprod_c >> (DEG_SH - 1));
	assign eldv_c   = 64'(elprod_c >> (DEG_SH - 1));

	// final wrap of a full turn
	logic [63:0] full_c;
	logic [63:0] azw_c;

	assign full_c = deg_q ? FULL_DEG : FULL_RAD;
	assign azw_c  = (az_s12 >= full_c) ? az_s12 - full_c : az_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1  <= point.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= sq_v[SQ_CELLS];
			v_s5  <= c1v[STEPS];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= c2v[STEPS];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= xr[N-1] ? N'(~xr + 1'b1) : xr;
			my_s1 <= yr[N-1] ? N'(~yr + 1'b1) : yr;
			mz_s1 <= zr[N-1] ? N'(~zr + 1'b1) : zr;
			xn_s1 <= xr[N-1];
			yn_s1 <= yr[N-1];
			zn_s1 <= zr[N-1];

			sqx_s2  <= sqx_c;
			sqy_s2  <= sqy_c;
			sqz_s2  <= sqz_c;
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			mz_s2   <= mz_s1;
			sh_s2   <= 7'd59 - c2s_pkg::bitlen(64'(big));
			xn_s2   <= xn_s1;
			yn_s2   <= yn_s1;
			zn_s2   <= zn_s1;
			zall_s2 <= (mx_s1 == '0) && (my_s1 == '0) && (mz_s1 == '0);
			zxy_s2  <= (mx_s1 == '0) && (my_s1 == '0);

			sum_s3     <= sum_c[SQ_W-1:0];
			sb_s3.sx   <= 64'(mx_s2) << sh_s2;
			sb_s3.sy   <= 64'(my_s2) << sh_s2;
			sb_s3.mz   <= mz_s2;
			sb_s3.sh   <= sh_s2;
			sb_s3.xn   <= xn_s2;
			sb_s3.yn   <= yn_s2;
			sb_s3.zn   <= zn_s2;
			sb_s3.zall <= zall_s2;
			sb_s3.zxy  <= zxy_s2;

			c1x_s4       <= sq_out.sx;
			c1y_s4       <= sq_out.sy;
			c1sb_s4.rad  <= rad_c[RW-1:0];
			c1sb_s4.mz   <= sq_out.mz;
			c1sb_s4.sh   <= sq_out.sh;
			c1sb_s4.xn   <= sq_out.xn;
			c1sb_s4.yn   <= sq_out.yn;
			c1sb_s4.zn   <= sq_out.zn;
			c1sb_s4.zall <= sq_out.zall;
			c1sb_s4.zxy  <= sq_out.zxy;

			az_s5 <= az_c;
			pl_s5 <= 64'(c1x[STEPS][31:0]) * 64'(c2s_pkg::INV_GAIN_Q32);
			ph_s5 <= 64'(c1x[STEPS][63:32]) * 64'(c2s_pkg::INV_GAIN_Q32);
			sb_s5 <= c1_out;

			rho_s6 <= 64'((rho_v >> 1) + 65'(rho_v[0]));
			az_s6  <= az_s5;
			sb_s6  <= sb_s5;

			rho_s7 <= rho_s6;
			az_s7  <= az_s6;
			k1_s7  <= $signed({2'b00, sb_s6.sh}) + t_c;
			k2_s7  <= t_c;
			sb_s7  <= sb_s6;

			c2x_s8       <= shift_by(64'(sb_s7.mz), k1_s7);
			c2y_s8       <= shift_by(rho_s7, k2_s7);
			c2sb_s8.rad  <= sb_s7.rad;
			c2sb_s8.az   <= az_s7;
			c2sb_s8.zn   <= sb_s7.zn;
			c2sb_s8.zall <= sb_s7.zall;
			c2sb_s8.zxy  <= sb_s7.zxy;

			az_s9  <= az9_c;
			el_s9  <= el9_c;
			rad_s9 <= c2_out.rad;

			azp_s10[0] <= 64'(az_s9[31:0]) * 64'(c2s_pkg::DEG_SCALE[31:0]);
			azp_s10[1] <= 64'(az_s9[31:0]) * 64'(c2s_pkg::DEG_SCALE[63:32]);
			azp_s10[2] <= 64'(az_s9[63:32]) * 64'(c2s_pkg::DEG_SCALE[31:0]);
			azp_s10[3] <= 64'(az_s9[63:32]) * 64'(c2s_pkg::DEG_SCALE[63:32]);
			elp_s10[0] <= 64'(el_s9[31:0]) * 64'(c2s_pkg::DEG_SCALE[31:0]);
			elp_s10[1] <= 64'(el_s9[31:0]) * 64'(c2s_pkg::DEG_SCALE[63:32]);
			elp_s10[2] <= 64'(el_s9[63:32]) * 64'(c2s_pkg::DEG_SCALE[31:0]);
			elp_s10[3] <= 64'(el_s9[63:32]) * 64'(c2s_pkg::DEG_SCALE[63:32]);
			azr_s10    <= (azrv_c >> 1) + {63'd0, azrv_c[0]};
			elr_s10    <= (elrv_c >> 1) + {63'd0, elrv_c[0]};
			rad_s10    <= rad_s9;

			azlo_s11  <= azp_s10[0];
			azhi_s11  <= azp_s10[3];
			azmid_s11 <= 65'(azp_s10[1]) + 65'(azp_s10[2]);
			ello_s11  <= elp_s10[0];
			elhi_s11  <= elp_s10[3];
			elmid_s11 <= 65'(elp_s10[1]) + 65'(elp_s10[2]);
			azr_s11   <= azr_s10;
			elr_s11   <= elr_s10;
			rad_s11   <= rad_s10;

			az_s12  <= deg_q ? (azdv_c >> 1) + {63'd0, azdv_c[0]} : azr_s11;
			el_s12  <= deg_q ? (eldv_c >> 1) + {63'd0, eldv_c[0]} : elr_s11;
			rad_s12 <= rad_s11;
		end
	end

	// output register with one skid entry
	logic                              out_valid_q;
	logic                              out_take;
	logic [RW-1:0]                     out_rad_q;
	logic [c2s_pkg::AZIMUTH_W-1:0]     out_az_q;
	logic [c2s_pkg::ELEVATION_W-1:0]   out_el_q;
	logic [RW-1:0]                     skid_rad_q;
	logic [c2s_pkg::AZIMUTH_W-1:0]     skid_az_q;
	logic [c2s_pkg::ELEVATION_W-1:0]   skid_el_q;

	assign out_take         = result.ready || !out_valid_q;
	assign result.valid     = out_valid_q;
	assign result.radius    = out_rad_q;
	assign result.azimuth   = out_az_q;
	assign result.elevation = out_el_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (v_s12) begin
			if (out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_rad_q <= skid_rad_q;
				out_az_q  <= skid_az_q;
				out_el_q  <= skid_el_q;
			end
		end else if (v_s12) begin
			if (out_take) begin
				out_rad_q <= rad_s12;
				out_az_q  <= azw_c[c2s_pkg::AZIMUTH_W-1:0];
				out_el_q  <= el_s12[c2s_pkg::ELEVATION_W-1:0];
			end else begin
				skid_rad_q <= rad_s12;
				skid_az_q  <= azw_c[c2s_pkg::AZIMUTH_W-1:0];
				skid_el_q  <= el_s12[c2s_pkg::ELEVATION_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/c2s_checker.sv
// c2s_checker: port-level checks on the cartesian to spherical top level
// depends on c2s_pkg; bound to cartesian_to_spherical below
`default_nettype none

module c2s_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_ready,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [c2s_pkg::RADIUS_W-1:0]       radius,
	input wire logic [c2s_pkg::AZIMUTH_W-1:0]      azimuth,
	input wire logic [c2s_pkg::ELEVATION_W-1:0]    elevation
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(azimuth)
			&& $stable(elevation))
		else $error("result changed while stalled");

	// ready only drops when the output was stalled
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("ready dropped without a stalled result");

	// a full skid entry implies a held result in front of it
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("ready low with no result shown");

	// the skid entry stays while the output is not taken
	a_skid_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready)
		else $error("buffered item lost");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.radius    (result.radius),
	.azimuth   (result.azimuth),
	.elevation (result.elevation)
);

`default_nettype wire
